// ----- hdl/gprr_pkg.sv -----
// Package: shared constants, types and tables for the grid phase ramp rotator.
`timescale 1ns / 1ps
package gprr_pkg;
    localparam int MaxDim       = 1024;
    localparam int SampleBits   = 16;
    localparam int PhaseBits    = 32;
    localparam int CordicSteps  = 16;
    localparam int IdxBits      = 10;
    localparam int SizeBits     = 11;
    localparam int WaveBits     = 24;
    localparam int CfgIdxBits   = 3;
    localparam int CfgDataBits  = 24;
    localparam int QueueDepth   = 4;
    localparam int QueuePtrBits = 2;
    localparam int CordicBits   = 34;

    localparam logic [CfgIdxBits-1:0] RegXSize  = 3'd0;
    localparam logic [CfgIdxBits-1:0] RegYSize  = 3'd1;
    localparam logic [CfgIdxBits-1:0] RegZSize  = 3'd2;
    localparam logic [CfgIdxBits-1:0] RegZOff   = 3'd3;
    localparam logic [CfgIdxBits-1:0] RegWaveX  = 3'd4;
    localparam logic [CfgIdxBits-1:0] RegWaveY  = 3'd5;
    localparam logic [CfgIdxBits-1:0] RegWaveZ  = 3'd6;

    localparam logic signed [CordicBits-1:0] InvGain = 34'sd652032874;

    typedef struct packed {
        logic signed [SampleBits-1:0] re;
        logic signed [SampleBits-1:0] im;
        logic                         last;
        logic [PhaseBits-1:0]         phase;
    } t_job;

    function automatic logic signed [CordicBits-1:0] atan_turn(input logic [3:0] k);
        logic signed [CordicBits-1:0] v;
        case (k)
            4'd0:  v = 34'sh020000000;
            4'd1:  v = 34'sh012E4051E;
            4'd2:  v = 34'sh009FB385B;
            4'd3:  v = 34'sh0051111D4;
            4'd4:  v = 34'sh0028B0D43;
            4'd5:  v = 34'sh00145D7E1;
            4'd6:  v = 34'sh000A2F61E;
            4'd7:  v = 34'sh000517C55;
            4'd8:  v = 34'sh00028BE53;
            4'd9:  v = 34'sh000145F2F;
            4'd10: v = 34'sh0000A2F98;
            4'd11: v = 34'sh0000517CC;
            4'd12: v = 34'sh000028BE6;
            4'd13: v = 34'sh0000145F3;
            4'd14: v = 34'sh00000A2FA;
            default: v = 34'sh00000517D;
        endcase
        return v;
    endfunction
endpackage

// ----- hdl/gprr_front.sv -----
// Front end: config registers, step division, index counters and phase per sample.
`timescale 1ns / 1ps
module gprr_front
    import gprr_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CfgIdxBits-1:0]        i_cfg_idx,
    input  logic [CfgDataBits-1:0]       i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [SampleBits-1:0] i_re,
    input  logic signed [SampleBits-1:0] i_im,
    input  logic                         i_last,
    output logic                         o_push,
    output t_job                         o_job,
    input  logic                         i_full
);
    typedef enum logic [2:0] {S_DIV, S_MUL, S_RUN} t_state;

    localparam int NumBits = WaveBits + PhaseBits - 16;
    localparam int DivSteps = NumBits;

    t_state r_state;
    logic [SizeBits-1:0] r_xs, r_ys, r_zs;
    logic [IdxBits-1:0]  r_zoff;
    logic [WaveBits-1:0] r_wx, r_wy, r_wz;
    logic [IdxBits-1:0]  r_xi, r_yi, r_zi;
    logic [PhaseBits-1:0] r_px, r_py, r_pz, r_sx, r_sy, r_sz;
    logic [1:0]          r_axis;
    logic [5:0]          r_cnt;
    logic [NumBits-1:0]  r_num;
    logic [SizeBits:0]   r_rem;
    logic [NumBits-1:0]  r_quo;

    function automatic logic [SizeBits-1:0] eff(input logic [SizeBits-1:0] v);
        if (v == '0) return SizeBits'(1);
        if (v > SizeBits'(MaxDim)) return SizeBits'(MaxDim);
        return v;
    endfunction

    logic [SizeBits-1:0] w_n;
    logic [WaveBits-1:0] w_wave;
    logic                w_neg;
    logic [WaveBits-1:0] w_mag;
    logic [SizeBits:0]   w_trial;
    logic [PhaseBits-1:0] w_step;
    logic [SizeBits-1:0] w_xe, w_ye;

    always_comb begin
        unique case (r_axis)
            2'd0:    begin w_n = eff(r_xs); w_wave = r_wx; end
            2'd1:    begin w_n = eff(r_ys); w_wave = r_wy; end
            default: begin w_n = eff(r_zs); w_wave = r_wz; end
        endcase
        w_neg  = w_wave[WaveBits-1];
        w_mag  = w_neg ? (~w_wave + 1'b1) : w_wave;
        w_trial = {r_rem[SizeBits-1:0], r_num[NumBits-1]};
        w_step = w_neg ? PhaseBits'(~r_quo + 1'b1) : PhaseBits'(r_quo);
        w_xe = eff(r_xs);
        w_ye = eff(r_ys);
    end

    assign o_ready = (r_state == S_RUN) && !i_full;
    assign o_push  = i_valid && o_ready;
    assign o_job.re = i_re;
    assign o_job.im = i_im;
    assign o_job.last = i_last;
    assign o_job.phase = r_px + r_py + r_pz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_DIV;
            r_xs <= SizeBits'(1); r_ys <= SizeBits'(1); r_zs <= SizeBits'(1);
            r_zoff <= '0; r_wx <= '0; r_wy <= '0; r_wz <= '0;
            r_axis <= '0; r_cnt <= '0;
            r_xi <= '0; r_yi <= '0; r_zi <= '0;
            r_px <= '0; r_py <= '0; r_pz <= '0;
        end else if (i_cfg_we && i_cfg_idx <= RegWaveZ) begin
            unique case (i_cfg_idx)
                RegXSize: r_xs <= i_cfg_data[SizeBits-1:0];
                RegYSize: r_ys <= i_cfg_data[SizeBits-1:0];
                RegZSize: r_zs <= i_cfg_data[SizeBits-1:0];
                RegZOff:  r_zoff <= i_cfg_data[IdxBits-1:0];
                RegWaveX: r_wx <= i_cfg_data;
                RegWaveY: r_wy <= i_cfg_data;
                default:  r_wz <= i_cfg_data;
            endcase
            r_state <= S_DIV; r_axis <= '0; r_cnt <= '0;
        end else begin
            unique case (r_state)
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_num <= {w_mag, 16'd0} + NumBits'(w_n >> 1);
                        r_rem <= '0;
                        r_cnt <= 6'd1;
                    end else if (r_cnt <= 6'(DivSteps)) begin
                        r_num <= {r_num[NumBits-2:0], 1'b0};
                        if (w_trial >= {1'b0, w_n}) begin
                            r_rem <= w_trial - {1'b0, w_n};
                            r_quo <= {r_quo[NumBits-2:0], 1'b1};
                        end else begin
                            r_rem <= w_trial;
                            r_quo <= {r_quo[NumBits-2:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        unique case (r_axis)
                            2'd0:    r_sx <= w_step;
                            2'd1:    r_sy <= w_step;
                            default: r_sz <= w_step;
                        endcase
                        r_cnt <= '0;
                        if (r_axis == 2'd2) begin
                            r_state <= S_MUL;
                            r_pz <= '0;
                        end else begin
                            r_axis <= r_axis + 1'b1;
                        end
                    end
                end
                S_MUL: begin
                    if (r_cnt == 6'(IdxBits)) begin
                        r_state <= S_RUN;
                    end else begin
                        r_pz <= r_pz + (r_zoff[4'(IdxBits-1) - r_cnt[3:0]] ?
                                        r_sz : '0) + r_pz;
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_xi <= '0; r_yi <= '0; r_zi <= '0;
                    r_px <= '0; r_py <= '0;
                end
                default: begin
                    if (o_push) begin
                        if (i_last) begin
                            r_state <= S_MUL; r_cnt <= '0; r_pz <= '0;
                        end else if (SizeBits'(r_xi) + 1'b1 < w_xe) begin
                            r_xi <= r_xi + 1'b1; r_px <= r_px + r_sx;
                        end else begin
                            r_xi <= '0; r_px <= '0;
                            if (SizeBits'(r_yi) + 1'b1 < w_ye) begin
                                r_yi <= r_yi + 1'b1; r_py <= r_py + r_sy;
                            end else begin
                                r_yi <= '0; r_py <= '0;
                                r_zi <= r_zi + 1'b1; r_pz <= r_pz + r_sz;
                            end
                        end
                    end
                end
            endcase
        end
    end
endmodule

// ----- hdl/gprr_queue.sv -----
// Short request queue between the front and back ends.
`timescale 1ns / 1ps
module gprr_queue
    import gprr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);
    t_job r_mem [QueueDepth];
    logic [QueuePtrBits-1:0] r_wp, r_rp;
    logic [QueuePtrBits:0]   r_cnt;

    assign o_full  = r_cnt == (QueuePtrBits+1)'(QueueDepth);
    assign o_empty = r_cnt == '0;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QueuePtrBits+1)'(i_push) - (QueuePtrBits+1)'(i_pop);
        end
    end
endmodule

// ----- hdl/gprr_back.sv -----
// Back end: iterative CORDIC, complex multiply, rounding and output register.
`timescale 1ns / 1ps
module gprr_back
    import gprr_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  t_job                          i_job,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SampleBits-1:0]  o_re,
    output logic signed [SampleBits-1:0]  o_im,
    output logic                          o_last
);
    typedef enum logic [2:0] {S_IDLE, S_ROT, S_MUL1, S_MUL2, S_DONE} t_state;
    localparam int ProdBits = SampleBits + CordicBits;

    t_state r_state;
    logic signed [CordicBits-1:0] r_cx, r_cy, r_z;
    logic [3:0] r_k;
    logic r_flip;
    t_job r_job;
    logic signed [ProdBits-1:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [ProdBits:0]   r_sr, r_si;

    logic signed [CordicBits-1:0] w_z0;
    logic signed [CordicBits-1:0] w_dx, w_dy;
    logic [31:0] w_t;

    always_comb begin
        w_t  = i_job.phase[PhaseBits-1 -: 32];
        w_z0 = CordicBits'($signed(w_t));
        w_dx = r_cy >>> r_k;
        w_dy = r_cx >>> r_k;
    end

    function automatic logic signed [SampleBits-1:0] rsat(input logic signed [ProdBits:0] v);
        logic signed [ProdBits:0] r;
        r = (v + (ProdBits+1)'(1 << 29)) >>> 30;
        if (r > (ProdBits+1)'((1 << (SampleBits-1)) - 1)) return {1'b0, {(SampleBits-1){1'b1}}};
        if (r < -(ProdBits+1)'(1 << (SampleBits-1))) return {1'b1, {(SampleBits-1){1'b0}}};
        return r[SampleBits-1:0];
    endfunction

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (!i_empty) begin
                    r_job <= i_job;
                    r_cx <= InvGain; r_cy <= '0; r_k <= '0;
                    if (w_z0 > CordicBits'(34'sd1073741824)) begin
                        r_z <= w_z0 - CordicBits'(34'sd2147483648); r_flip <= 1'b1;
                    end else if (w_z0 < -CordicBits'(34'sd1073741824)) begin
                        r_z <= w_z0 + CordicBits'(34'sd2147483648); r_flip <= 1'b1;
                    end else begin
                        r_z <= w_z0; r_flip <= 1'b0;
                    end
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (!r_z[CordicBits-1]) begin
                        r_cx <= r_cx - w_dx; r_cy <= r_cy + w_dy; r_z <= r_z - atan_turn(r_k);
                    end else begin
                        r_cx <= r_cx + w_dx; r_cy <= r_cy - w_dy; r_z <= r_z + atan_turn(r_k);
                    end
                    r_k <= r_k + 1'b1;
                    if (r_k == 4'(CordicSteps-1)) r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_p0 <= r_job.re * (r_flip ? -r_cx : r_cx);
                    r_p1 <= r_job.im * (r_flip ? -r_cy : r_cy);
                    r_p2 <= r_job.re * (r_flip ? -r_cy : r_cy);
                    r_p3 <= r_job.im * (r_flip ? -r_cx : r_cx);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_sr <= (ProdBits+1)'(r_p0) - (ProdBits+1)'(r_p1);
                    r_si <= (ProdBits+1)'(r_p2) + (ProdBits+1)'(r_p3);
                    r_state <= S_DONE;
                end
                default: begin
                    if (!o_valid || i_ready) begin
                        o_re <= rsat(r_sr); o_im <= rsat(r_si); o_last <= r_job.last;
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
            endcase
            if (o_valid && i_ready && r_state != S_DONE) o_valid <= 1'b0;
        end
    end
endmodule

// ----- hdl/grid_phase_ramp_rotator_core.sv -----
// Top level: grid phase ramp rotator with decoupled front and back ends.
// Each request passes in turn through the back end: a load state, 16 CORDIC
// iterations on a shared shift-add unit, a multiply state, an add state and
// the output register; a new request is taken only once the last one is in
// the output register. A stalled result holds the back end and, once the
// four-entry queue fills, the input. After a config write or reset the front
// end forms the steps (a bit-serial divide per axis) and the z-offset phase;
// after a last sample it forms the z-offset phase again. The input is not
// ready meanwhile.
`timescale 1ns / 1ps
module grid_phase_ramp_rotator_core
    import gprr_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CfgIdxBits-1:0]        i_cfg_idx,
    input  logic [CfgDataBits-1:0]       i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [SampleBits-1:0] i_sample_re,
    input  logic signed [SampleBits-1:0] i_sample_im,
    input  logic                         i_last_in,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [SampleBits-1:0] o_result_re,
    output logic signed [SampleBits-1:0] o_result_im,
    output logic                         o_last_out
);
    logic push, full, pop, empty;
    t_job fjob, qjob;

    gprr_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .o_ready, .i_re(i_sample_re), .i_im(i_sample_im),
        .i_last(i_last_in), .o_push(push), .o_job(fjob), .i_full(full)
    );
    gprr_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_job(fjob), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_job(qjob)
    );
    gprr_back u_back (
        .i_clk, .i_rst_n, .i_empty(empty), .i_job(qjob), .o_pop(pop),
        .o_valid, .i_ready, .o_re(o_result_re), .o_im(o_result_im),
        .o_last(o_last_out)
    );
endmodule
